@@ hdl/audio_ring_fifo_drop_oldest_assert.svh @@
// Assertion macros used by the checker file of the audio ring FIFO.
`ifndef AUDIO_RING_FIFO_DROP_OLDEST_ASSERT_SVH
`define AUDIO_RING_FIFO_DROP_OLDEST_ASSERT_SVH

// Implication checked in the same cycle.
`define ARF_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define ARF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/arf_pkg.sv @@
// Package with the shared widths, codes and types of the audio ring FIFO.
`timescale 1ns / 1ps
package arf_pkg;

    localparam int RING_DEPTH_DEF = 32768;

    localparam int OP_W       = 2;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int FRAME_W    = 6;
    localparam int CNT_W      = 32;
    localparam int PLAY_W     = 48;
    localparam int FILL_W     = 16;
    localparam int CMP_W      = LEN_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_USER_W = 2;

    localparam logic [LEN_W-1:0]   CAP_RESET   = 16'd4096;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 6'd4;

    typedef enum logic [OP_W-1:0] {
        OP_SUB_HDR  = 2'd0,
        OP_SUB_BYTE = 2'd1,
        OP_PULL_HDR = 2'd2,
        OP_PULL_BYTE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 2'd0,
        REG_FRAME    = 2'd1,
        REG_ENABLED  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic               done;
        logic [FRAME_W-1:0] rem;
    } div_stat_t;

endpackage

@@ hdl/arf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module arf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/arf_rem.sv @@
// Bit-serial remainder unit that divides a byte count by the frame size.
`timescale 1ns / 1ps
module arf_rem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [arf_pkg::LEN_W-1:0]    dividend,
    input  logic [arf_pkg::FRAME_W-1:0]  divisor,
    output arf_pkg::div_stat_t           stat
);
    import arf_pkg::*;

    localparam int STEP_W = $clog2(LEN_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [LEN_W-1:0]    num_reg, num_next;
    logic [FRAME_W-1:0]  div_reg, div_next;
    logic [FRAME_W-1:0]  rem_reg, rem_next;
    logic [FRAME_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[LEN_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = STEP_W'(LEN_W);
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = FRAME_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[FRAME_W-1:0];
            end
            num_next  = {num_reg[LEN_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            num_reg  <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            num_reg  <= num_next;
            div_reg  <= div_next;
            rem_reg  <= rem_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

@@ hdl/audio_ring_fifo_drop_oldest.sv @@
// Top level of the byte ring FIFO for PCM audio that drops the oldest frames.
// Submit bytes, pull headers and pull bytes never start the remainder unit,
// and a pull byte reads the ring RAM through its registered read port into
// a result stage that sits ahead of the output register. A submit header
// does not start it either, unless the free space is short: then the drop is
// rounded up to whole frames by a bit-serial remainder unit, and the header
// holds off the next request while that unit starts, steps once per length
// bit and finishes, longer if the result stage is still waiting on the output. Every
// request yields one result on the master side. Configuration writes are taken in
// any cycle and must only be issued while the block is idle; a write of the
// ring capacity empties the ring. The ring RAM needs no clearing after
// reset, since no entry is read before it has been written.
`timescale 1ns / 1ps
module audio_ring_fifo_drop_oldest #(
    parameter int RING_DEPTH = arf_pkg::RING_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // length [15:0], data_byte [23:16]
    input  logic [arf_pkg::IN_DATA_W-1:0]    s_tdata,
    // op [1:0]
    input  logic [arf_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_byte [7:0], accepted [23:8], overflow_count [55:24],
    // underflow_count [87:56], bytes_played [135:88], fill_level [151:136]
    output logic [arf_pkg::OUT_DATA_W-1:0]   m_tdata,
    // padded [0], silent_period [1]
    output logic [arf_pkg::OUT_USER_W-1:0]   m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [arf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import arf_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);

    typedef enum logic {ST_RUN, ST_DIV} state_t;

    typedef struct packed {
        logic               rd;
        logic               pad;
        logic               sil;
        logic [LEN_W-1:0]   acc;
        logic [CNT_W-1:0]   ovf;
        logic [CNT_W-1:0]   unf;
        logic [PLAY_W-1:0]  played;
        logic [FILL_W-1:0]  fill;
    } res_t;

    state_t              st_reg, st_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [PW-1:0]       rp_reg, rp_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]    skip_reg, skip_next;
    logic [LEN_W-1:0]    wleft_reg, wleft_next;
    logic [LEN_W-1:0]    prl_reg, prl_next;
    logic [CNT_W-1:0]    ovf_reg, ovf_next;
    logic [CNT_W-1:0]    unf_reg, unf_next;
    logic [PLAY_W-1:0]   played_reg, played_next;
    logic [LEN_W-1:0]    cap_cfg_reg, cap_cfg_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic                en_reg, en_next;
    logic [LEN_W-1:0]    need_reg, need_next;
    logic [LEN_W-1:0]    size_reg, size_next;
    logic                s1_valid_reg, s1_valid_next;
    res_t                s1_reg, s1_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic [CMP_W-1:0]    cap;
    logic [FRAME_W-1:0]  fb;
    op_t                 op;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   dbyte;
    logic [CMP_W-1:0]    len_w;
    logic [CMP_W-1:0]    size_w;
    logic [CMP_W-1:0]    freeb;
    logic                clip;
    logic                space_short;
    logic                s1_move;
    logic                s1_free;
    logic                acc;
    logic                fin;
    logic                div_start;
    div_stat_t           div_stat;
    logic [FRAME_W-1:0]  pad_amt;
    logic [CMP_W-1:0]    drop_w;
    logic [CMP_W-1:0]    rp_sum;
    logic [LEN_W-1:0]    pull_n;
    logic                ram_we;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   res_byte;

    assign op    = op_t'(s_tuser[OP_W-1:0]);
    assign len   = s_tdata[LEN_W-1:0];
    assign dbyte = s_tdata[LEN_W+BYTE_W-1:LEN_W];
    assign len_w = CMP_W'(len);

    assign cap = (cap_cfg_reg == '0) ? CMP_W'(1) :
                 (CMP_W'(cap_cfg_reg) > CMP_W'(RING_DEPTH)) ? CMP_W'(RING_DEPTH) :
                 CMP_W'(cap_cfg_reg);
    assign fb  = (frame_reg == '0) ? FRAME_W'(1) : frame_reg;

    assign size_w      = clip ? cap : len_w;
    assign clip        = len_w > cap;
    assign freeb       = (cap > CMP_W'(fill_reg)) ? cap - CMP_W'(fill_reg) : '0;
    assign space_short = freeb < size_w;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_free  = !s1_valid_reg || s1_move;
    assign s_tready = (st_reg == ST_RUN) && s1_free;
    assign acc      = s_tvalid && s_tready;
    assign fin      = (st_reg == ST_DIV) && div_stat.done && s1_free;
    assign cfg_ready = 1'b1;

    assign pad_amt = (div_stat.rem == '0) ? '0 : fb - div_stat.rem;
    assign pull_n  = (len < fill_reg) ? len : fill_reg;

    always_comb
    begin
        st_next      = st_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        fill_next    = fill_reg;
        skip_next    = skip_reg;
        wleft_next   = wleft_reg;
        prl_next     = prl_reg;
        ovf_next     = ovf_reg;
        unf_next     = unf_reg;
        played_next  = played_reg;
        cap_cfg_next = cap_cfg_reg;
        frame_next   = frame_reg;
        en_next      = en_reg;
        need_next    = need_reg;
        size_next    = size_reg;
        s1_next      = s1_reg;
        div_start    = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        drop_w       = '0;
        rp_sum       = '0;

        if (acc)
        begin
            s1_next = '0;
            case (op)
                OP_SUB_HDR:
                begin
                    if (len == '0 || !en_reg)
                    begin
                        skip_next  = len;
                        wleft_next = '0;
                    end
                    else
                    begin
                        skip_next  = clip ? LEN_W'(len_w - cap) : '0;
                        ovf_next   = ovf_reg + CNT_W'(clip);
                        wleft_next = LEN_W'(size_w);
                        s1_next.acc = LEN_W'(size_w);
                        if (space_short)
                        begin
                            div_start = 1'b1;
                            need_next = LEN_W'(size_w - freeb);
                            size_next = LEN_W'(size_w);
                            st_next   = ST_DIV;
                        end
                    end
                end
                OP_SUB_BYTE:
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_reg - 1'b1;
                    end
                    else if (wleft_reg != '0)
                    begin
                        wleft_next = wleft_reg - 1'b1;
                        if (CMP_W'(fill_reg) < cap)
                        begin
                            ram_we    = 1'b1;
                            wp_next   = (CMP_W'(wp_reg) + 1'b1 == cap) ? '0 : wp_reg + 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
                OP_PULL_HDR:
                begin
                    prl_next = pull_n;
                    unf_next = unf_reg + CNT_W'(pull_n < len);
                    s1_next.sil = (pull_n == '0);
                end
                OP_PULL_BYTE:
                begin
                    if (prl_reg != '0 && fill_reg != '0)
                    begin
                        ram_re      = 1'b1;
                        rp_next     = (CMP_W'(rp_reg) + 1'b1 == cap) ? '0 : rp_reg + 1'b1;
                        fill_next   = fill_reg - 1'b1;
                        prl_next    = prl_reg - 1'b1;
                        played_next = played_reg + 1'b1;
                        s1_next.rd  = 1'b1;
                    end
                    else
                    begin
                        prl_next    = '0;
                        s1_next.pad = 1'b1;
                    end
                end
                default:
                begin
                    s1_next = '0;
                end
            endcase
        end

        if (fin)
        begin
            drop_w = CMP_W'(need_reg) + CMP_W'(pad_amt);
            if (drop_w > CMP_W'(fill_reg))
            begin
                drop_w = CMP_W'(fill_reg);
            end
            rp_sum = CMP_W'(rp_reg) + drop_w;
            if (rp_sum >= cap)
            begin
                rp_sum = rp_sum - cap;
            end
            rp_next   = PW'(rp_sum);
            fill_next = fill_reg - FILL_W'(drop_w);
            if (prl_reg > fill_next)
            begin
                prl_next = fill_next;
            end
            ovf_next = ovf_reg + 1'b1;
            s1_next  = '0;
            s1_next.acc = size_reg;
            st_next  = ST_RUN;
        end

        s1_next.ovf    = ovf_next;
        s1_next.unf    = unf_next;
        s1_next.played = played_next;
        s1_next.fill   = fill_next;

        if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CAPACITY:
                begin
                    cap_cfg_next = cfg_data[LEN_W-1:0];
                    wp_next      = '0;
                    rp_next      = '0;
                    fill_next    = '0;
                    skip_next    = '0;
                    wleft_next   = '0;
                    prl_next     = '0;
                end
                REG_FRAME:
                begin
                    frame_next = cfg_data[FRAME_W-1:0];
                end
                REG_ENABLED:
                begin
                    en_next = cfg_data[0];
                end
                default:
                begin
                    en_next = en_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {s1_reg.fill, s1_reg.played, s1_reg.unf, s1_reg.ovf,
                              s1_reg.acc, res_byte};
            out_user_next  = {s1_reg.sil, s1_reg.pad};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((acc && !div_start) || fin)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign res_byte = s1_reg.rd ? ram_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RUN;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            skip_reg      <= '0;
            wleft_reg     <= '0;
            prl_reg       <= '0;
            ovf_reg       <= '0;
            unf_reg       <= '0;
            played_reg    <= '0;
            cap_cfg_reg   <= CAP_RESET;
            frame_reg     <= FRAME_RESET;
            en_reg        <= 1'b0;
            need_reg      <= '0;
            size_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            wleft_reg     <= wleft_next;
            prl_reg       <= prl_next;
            ovf_reg       <= ovf_next;
            unf_reg       <= unf_next;
            played_reg    <= played_next;
            cap_cfg_reg   <= cap_cfg_next;
            frame_reg     <= frame_next;
            en_reg        <= en_next;
            need_reg      <= need_next;
            size_reg      <= size_next;
            s1_valid_reg  <= s1_valid_next;
            s1_reg        <= s1_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
        end
    end

    arf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (dbyte),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    arf_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (need_next),
        .divisor  (fb),
        .stat     (div_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ hdl/arf_checker.sv @@
// Port checker for the audio ring FIFO and the bind that attaches it.
`timescale 1ns / 1ps
`include "audio_ring_fifo_drop_oldest_assert.svh"
module arf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [arf_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [arf_pkg::OUT_USER_W-1:0]   m_tuser
);

    // A padded result never carries a stored byte.
    `ARF_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'd0, "padded byte not zero")

    // Padding comes from pull bytes and silence from pull headers only.
    `ARF_ASSERT_NOW(a_kind_excl, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]), "padded and silent together")

    // A nonzero accepted count only comes from a submit header.
    `ARF_ASSERT_NOW(a_acc_hdr, clk, rst_n, m_tvalid && (m_tdata[23:8] != 16'd0), (m_tuser == 2'b00) && (m_tdata[7:0] == 8'd0), "accepted count on a non-header result")

    // A stalled result holds its payload.
    `ARF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind audio_ring_fifo_drop_oldest arf_checker u_arf_checker (.*);
